// ----- hdl/search_open_list_queue_macros.svh -----
// Assertion macros for the open list queue.
`ifndef SEARCH_OPEN_LIST_QUEUE_MACROS_SVH
`define SEARCH_OPEN_LIST_QUEUE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SOLQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SOLQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hdl/solq_pkg.sv -----
// ----------------------------------------------------------------------------
// solq_pkg
// Shared types and status codes of the open list queue.
// ----------------------------------------------------------------------------
package solq_pkg;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_IMPROVED  = 3'd1,
    ST_KEPT      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  localparam int unsigned CostBits = 16;

  // Command broadcast to every cell in the delete and insert steps of an operation.
  typedef struct packed {
    logic del;   // remove the matching entry (shift left from it)
    logic ins;   // insert the new entry at its sorted slot
  } cell_cmd_t;

endpackage

// ----- hdl/solq_if.sv -----
// ----------------------------------------------------------------------------
// solq_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface solq_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/solq_cell.sv -----
// ----------------------------------------------------------------------------
// solq_cell
// One slot of the sorted list: holds an entry, compares it against the
// offered beat and shifts left or right with its neighbors.
// ----------------------------------------------------------------------------
module solq_cell #(
  parameter int unsigned CoordBits = 8
) (
  input  logic                         clk_i,
  input  logic [CoordBits-1:0]         key_x_i,
  input  logic [CoordBits-1:0]         key_y_i,
  input  logic [solq_pkg::CostBits-1:0] key_eval_i,
  input  logic                         occ_i,      // slot index < count
  input  logic [4*CoordBits+2*solq_pkg::CostBits-1:0] new_i,
  input  logic [4*CoordBits+2*solq_pkg::CostBits-1:0] left_i,
  input  logic [4*CoordBits+2*solq_pkg::CostBits-1:0] right_i,
  input  logic                         left_del_i,  // delete point is left
  input  logic                         left_ins_i,  // insert point is left
  input  logic                         left_gt_i,   // this slot's key >= new
  input  solq_pkg::cell_cmd_t          cmd_i,
  input  logic                         go_i,
  output logic [4*CoordBits+2*solq_pkg::CostBits-1:0] entry_o,
  output logic                         match_o,
  output logic                         after_del_o,
  output logic                         after_ins_o,
  output logic                         gt_o
);
  localparam int unsigned EW = 4*CoordBits + 2*solq_pkg::CostBits;

  logic [EW-1:0] ent_q, mid;
  logic          del_here, ins_here;

  // Entry layout: x, y, path, eval, px, py (x at the top).
  assign entry_o = ent_q;
  assign match_o = occ_i && ent_q[EW-1 -: CoordBits] == key_x_i &&
                   ent_q[EW-1-CoordBits -: CoordBits] == key_y_i;
  assign gt_o    = ent_q[2*CoordBits +: solq_pkg::CostBits] >= key_eval_i && occ_i;

  assign del_here    = cmd_i.del && (left_del_i || match_o);
  assign after_del_o = del_here;
  // Insert point is the first slot (after delete) that is empty or holds a key >= new.
  assign ins_here    = cmd_i.ins && !left_ins_i && (left_gt_i || !occ_i);
  assign after_ins_o = left_ins_i || ins_here;

  always_comb begin
    mid = ent_q;
    if (cmd_i.ins && left_ins_i) begin
      mid = left_i;
    end else if (ins_here) begin
      mid = new_i;
    end
  end

  // Entry register, no reset needed for payload.
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      if (del_here) begin
        ent_q <= right_i;
      end else begin
        ent_q <= mid;
      end
    end
  end
endmodule

// ----- hdl/search_open_list_queue.sv -----
// Sequence: a taken request beat runs compare and delete shift, then insert
// shift, then the registered result beat, held until taken, then idle.
// No new request is taken until the result beat is taken and the block
// is back in idle.
// Reset: the entry count and all handshake state clear; entries are not
// cleared, only slots below the count are ever read.
// ----------------------------------------------------------------------------
// search_open_list_queue
// Sorted open list built as a chain of cells with decrease-key.
// ----------------------------------------------------------------------------
`include "search_open_list_queue_macros.svh"
module search_open_list_queue #(
  parameter int unsigned LIST_DEPTH = 64,
  parameter int unsigned COORD_BITS = 8
) (
  input logic clk_i,
  input logic rst_ni,
  solq_if.sink   req_i,
  solq_if.source rsp_o
);
  localparam int unsigned CB = solq_pkg::CostBits;
  localparam int unsigned EW = 4*COORD_BITS + 2*CB;
  localparam int unsigned NW = $clog2(LIST_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_DEL, S_INS, S_OUT} state_e;

  state_e state_q;
  logic [NW-1:0] cnt_q;
  logic [EW-1:0] new_q;
  logic req_q;
  logic [CB-1:0] npath_q;
  solq_pkg::status_e st_q;
  solq_pkg::cell_cmd_t cmd;
  logic go;

  logic [EW-1:0] ent [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] match, adel, ains, gt;
  logic [EW-1:0] hit_ent;
  logic found;

  // Cell chain.
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    solq_cell #(.CoordBits(COORD_BITS)) u_cell (
      .clk_i,
      .key_x_i   (new_q[EW-1 -: COORD_BITS]),
      .key_y_i   (new_q[EW-1-COORD_BITS -: COORD_BITS]),
      .key_eval_i(new_q[2*COORD_BITS +: CB]),
      .occ_i     (NW'(i) < cnt_q),
      .new_i     (new_q),
      .left_i    ((i == 0) ? new_q : ent[(i == 0) ? 0 : i-1]),
      .right_i   ((i == LIST_DEPTH-1) ? ent[i] : ent[(i == LIST_DEPTH-1) ? i : i+1]),
      .left_del_i((i == 0) ? 1'b0 : adel[(i == 0) ? 0 : i-1]),
      .left_ins_i((i == 0) ? 1'b0 : ains[(i == 0) ? 0 : i-1]),
      .left_gt_i (gt[i]),
      .cmd_i     (cmd),
      .go_i      (go),
      .entry_o   (ent[i]),
      .match_o   (match[i]),
      .after_del_o(adel[i]),
      .after_ins_o(ains[i]),
      .gt_o      (gt[i])
    );
  end

  // Matched entry (at most one).
  always_comb begin
    hit_ent = '0;
    for (int k = 0; k < LIST_DEPTH; k++) begin
      if (match[k]) hit_ent = ent[k];
    end
  end
  assign found = |match;

  always_comb begin
    cmd = '0;
    go  = 1'b0;
    if (state_q == S_DEL && found &&
        (req_q || npath_q < hit_ent[2*COORD_BITS+CB +: CB])) begin
      cmd.del = 1'b1;
      go = 1'b1;
    end else if (state_q == S_INS && (st_q == solq_pkg::ST_INSERTED ||
                                      st_q == solq_pkg::ST_IMPROVED)) begin
      cmd.ins = 1'b1;
      go = 1'b1;
    end
  end

  assign req_i.ready = (state_q == S_IDLE);

  // Sequencer: compare/delete, insert, present.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rsp_o.valid <= 1'b0;
      st_q    <= solq_pkg::ST_INSERTED;
      req_q   <= 1'b0;
      npath_q <= '0;
      new_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            req_q   <= req_i.data.req_type;
            npath_q <= req_i.data.travel_cost;
            new_q   <= {req_i.data.node_x[COORD_BITS-1:0],
                        req_i.data.node_y[COORD_BITS-1:0],
                        req_i.data.travel_cost, req_i.data.rank_cost,
                        req_i.data.prev_x[COORD_BITS-1:0],
                        req_i.data.prev_y[COORD_BITS-1:0]};
            state_q <= S_DEL;
          end
        end
        S_DEL: begin
          if (req_q) begin
            st_q <= found ? solq_pkg::ST_REMOVED : solq_pkg::ST_NOT_FOUND;
            if (found) cnt_q <= cnt_q - 1'b1;
          end else if (found) begin
            if (cmd.del) begin
              st_q  <= solq_pkg::ST_IMPROVED;
              cnt_q <= cnt_q - 1'b1;
            end else begin
              st_q <= solq_pkg::ST_KEPT;
            end
          end else if (cnt_q >= NW'(LIST_DEPTH)) begin
            st_q <= solq_pkg::ST_FULL;
          end else begin
            st_q <= solq_pkg::ST_INSERTED;
          end
          state_q <= S_INS;
        end
        S_INS: begin
          if (cmd.ins) cnt_q <= cnt_q + 1'b1;
          state_q <= S_OUT;
          rsp_o.valid <= 1'b1;
        end
        S_OUT: begin
          if (rsp_o.ready) begin
            rsp_o.valid <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Result beat: status, entry count and the list head.
  logic hv;
  assign hv = cnt_q != '0;
  always_comb begin
    rsp_o.data.status      = st_q;
    rsp_o.data.head_valid  = hv;
    rsp_o.data.head_x      = hv ? 8'(ent[0][EW-1 -: COORD_BITS]) : '0;
    rsp_o.data.head_y      = hv ? 8'(ent[0][EW-1-COORD_BITS -: COORD_BITS]) : '0;
    rsp_o.data.head_path   = hv ? ent[0][2*COORD_BITS+CB +: CB] : '0;
    rsp_o.data.head_eval   = hv ? ent[0][2*COORD_BITS +: CB] : '0;
    rsp_o.data.head_prev_x = hv ? 8'(ent[0][COORD_BITS +: COORD_BITS]) : '0;
    rsp_o.data.head_prev_y = hv ? 8'(ent[0][0 +: COORD_BITS]) : '0;
    rsp_o.data.entry_count = 7'(cnt_q);
  end

  `SOLQ_ASSERT_IMP(a_count_max, clk_i, rst_ni, 1'b1, cnt_q <= NW'(LIST_DEPTH))
  `SOLQ_ASSERT_IMP(a_one_match, clk_i, rst_ni, 1'b1, $onehot0(match))
  `SOLQ_ASSERT_NXT(a_full_keep, clk_i, rst_ni, state_q == S_INS && st_q == solq_pkg::ST_FULL, $stable(cnt_q))
endmodule
